// File: sv/wwt_pkg.sv
// Shared constants for the windowed waypoint tracker: field widths,
// function codes and parameter defaults. No dependencies.
package wwt_pkg;

    // Fixed field widths of the item and result words
    localparam int FUNC_BITS  = 2;
    localparam int SLOT_BITS  = 10;
    localparam int POS_BITS   = 20;
    localparam int INDEX_BITS = 10;
    localparam int COUNT_BITS = 11;

    // Parameter defaults
    localparam int MAX_POINTS_DEF = 1024;
    localparam int WINDOW_CAP_DEF = 50;
    localparam int COORD_BITS_DEF = 20;

    // Smallest loop size
    localparam int MIN_COUNT = 2;

    // Function codes
    localparam logic [FUNC_BITS-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_LOCATE  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_ADVANCE = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_NOP     = 2'd3;

endpackage

// File: sv/wwt_if.sv
// Handshake channels of the windowed waypoint tracker: item and result words.
// Depends on wwt_pkg for field widths.
interface wwt_item_if;
    logic                                   valid;
    logic                                   ready;
    logic        [wwt_pkg::FUNC_BITS-1:0]   func;
    logic        [wwt_pkg::SLOT_BITS-1:0]   slot;
    logic signed [wwt_pkg::POS_BITS-1:0]    pos_x;
    logic signed [wwt_pkg::POS_BITS-1:0]    pos_y;

    modport source (output valid, func, slot, pos_x, pos_y, input ready);
    modport sink   (input valid, func, slot, pos_x, pos_y, output ready);
endinterface

interface wwt_result_if;
    logic                                   valid;
    logic                                   ready;
    logic        [wwt_pkg::INDEX_BITS-1:0]  current_index;
    logic                                   lap_done;
    logic        [wwt_pkg::INDEX_BITS-1:0]  lap_progress;

    modport source (output valid, current_index, lap_done, lap_progress, input ready);
    modport sink   (input valid, current_index, lap_done, lap_progress, output ready);
endinterface

// File: sv/wwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wwt_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/windowed_waypoint_tracker.sv
// Top level of the windowed waypoint tracker: control sequencer, distance
// pipeline and lap bookkeeping. Depends on wwt_pkg, wwt_if and wwt_ram.
//
//  channel  | dir | word fields                               | handshake
//  ---------+-----+-------------------------------------------+-------------
//  item     | in  | func, slot, pos_x, pos_y                  | valid/ready
//  result   | out | current_index, lap_done, lap_progress     | valid/ready
//  cfg      | in  | cfg_wdata (waypoint_count)                | cfg_we only
//
// Items: one item at a time. A locate reads all n waypoints and an advance
// min(n/2, WINDOW_CAP) of them, both through the single read port of the
// waypoint RAM (one entry a cycle) and the four-stage distance pipeline; an
// advance from a stale index first runs a bit-serial remainder. Reset clears
// the index and lap count and sets the count register to 2; the RAM is not
// cleared. A stalled result holds in the output register while the next item
// is taken in; that item waits in its final step until the result word is
// gone.
module windowed_waypoint_tracker #(
    parameter int MAX_POINTS = wwt_pkg::MAX_POINTS_DEF,
    parameter int WINDOW_CAP = wwt_pkg::WINDOW_CAP_DEF,
    parameter int COORD_BITS = wwt_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wwt_pkg::COUNT_BITS-1:0]   cfg_wdata,
    wwt_item_if.sink                         item,
    wwt_result_if.source                     result
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int BIT_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int CB    = COORD_BITS;
    localparam int SQ_W  = 2 * CB;
    localparam int D_W   = SQ_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODR,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Control state
    state_t                             state_reg, state_next;
    logic [wwt_pkg::COUNT_BITS-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]                   track_reg, track_next;
    logic [CNT_W-1:0]                   progress_reg, progress_next;
    logic [IDX_W-1:0]                   ptr_reg, ptr_next;
    logic [CNT_W-1:0]                   left_reg, left_next;
    logic [IDX_W-1:0]                   start_reg, start_next;
    logic [CNT_W-1:0]                   rem_reg, rem_next;
    logic [BIT_W-1:0]                   bit_reg, bit_next;
    logic                               first_reg, first_next;
    logic                               v1_reg, v1_next;
    logic                               v2_reg, v2_next;
    logic                               v3_reg, v3_next;
    logic                               out_valid_reg, out_valid_next;
    logic [wwt_pkg::INDEX_BITS-1:0]     out_index_reg, out_index_next;
    logic                               out_done_reg, out_done_next;
    logic [wwt_pkg::INDEX_BITS-1:0]     out_prog_reg, out_prog_next;

    // Datapath registers
    logic [wwt_pkg::FUNC_BITS-1:0]      func_reg;
    logic signed [CB-1:0]               px_reg, py_reg;
    logic [IDX_W-1:0]                   idx1_reg, idx2_reg, idx3_reg;
    logic [CB-1:0]                      ax_reg, ay_reg;
    logic [SQ_W-1:0]                    sqx_reg, sqy_reg;
    logic [D_W-1:0]                     best_d_reg;
    logic [IDX_W-1:0]                   best_idx_reg;

    logic                               accept;
    logic [CNT_W-1:0]                   n_eff;
    logic [CNT_W-1:0]                   win;
    logic signed [CB-1:0]               in_x, in_y;
    logic                               ram_we;
    logic [IDX_W-1:0]                   ram_waddr;
    logic [IDX_W-1:0]                   ram_raddr;
    logic [2*CB-1:0]                    ram_rdata;
    logic signed [CB-1:0]               tx, ty;
    logic signed [CB:0]                 dx, dy;
    logic [D_W-1:0]                     dist_sum;
    logic                               take_best;
    logic [CNT_W:0]                     rem_shift;
    logic [CNT_W-1:0]                   adv;
    logic [CNT_W:0]                     prog_sum;
    logic                               out_free;

    assign accept       = item.valid && item.ready;
    assign item.ready   = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.current_index = out_index_reg;
    assign result.lap_done      = out_done_reg;
    assign result.lap_progress  = out_prog_reg;
    assign out_free     = !out_valid_reg || result.ready;

    // Wrap the incoming coordinates to the stored width
    assign in_x = CB'(item.pos_x);
    assign in_y = CB'(item.pos_y);

    // Saturate the loop size to [2, MAX_POINTS]
    always_comb
    begin
        if (32'(count_reg) < wwt_pkg::MIN_COUNT)
        begin
            n_eff = CNT_W'(wwt_pkg::MIN_COUNT);
        end
        else if (32'(count_reg) > MAX_POINTS)
        begin
            n_eff = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = CNT_W'(count_reg);
        end
    end

    // Forward window: half the loop, capped
    always_comb
    begin
        if (32'(n_eff >> 1) > WINDOW_CAP)
        begin
            win = CNT_W'(WINDOW_CAP);
        end
        else
        begin
            win = n_eff >> 1;
        end
    end

    // Load writes go straight to the RAM at the accept edge
    assign ram_we    = accept && (item.func == wwt_pkg::FUNC_LOAD) &&
                       (32'(item.slot) < MAX_POINTS);
    assign ram_waddr = IDX_W'(item.slot);
    assign ram_raddr = ptr_reg;

    wwt_ram #(
        .WIDTH (2 * CB),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_x, in_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Distance pipeline: difference, square, sum and compare
    assign tx   = ram_rdata[2*CB-1:CB];
    assign ty   = ram_rdata[CB-1:0];
    assign dx   = {px_reg[CB-1], px_reg} - {tx[CB-1], tx};
    assign dy   = {py_reg[CB-1], py_reg} - {ty[CB-1], ty};
    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    // Strict compare keeps the first entry met on ties
    assign take_best = v3_reg && (first_reg || (dist_sum < best_d_reg));

    // Bit-serial remainder step for a stale index
    assign rem_shift = {rem_reg, track_reg[bit_reg]};

    // Forward distance moved, with wrap
    always_comb
    begin
        if (best_idx_reg >= start_reg)
        begin
            adv = CNT_W'(best_idx_reg) - CNT_W'(start_reg);
        end
        else
        begin
            adv = CNT_W'(best_idx_reg) + n_eff - CNT_W'(start_reg);
        end
    end
    assign prog_sum = {1'b0, progress_reg} + {1'b0, adv};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        track_next     = track_reg;
        progress_next  = progress_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        start_next     = start_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        first_next     = take_best ? 1'b0 : first_reg;
        v1_next        = 1'b0;
        v2_next        = v1_reg;
        v3_next        = v2_reg;
        out_valid_next = result.ready ? 1'b0 : out_valid_reg;
        out_index_next = out_index_reg;
        out_done_next  = out_done_reg;
        out_prog_next  = out_prog_reg;

        if (cfg_we)
        begin
            count_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    first_next = 1'b1;
                    case (item.func)
                        wwt_pkg::FUNC_LOCATE:
                        begin
                            ptr_next   = '0;
                            start_next = '0;
                            left_next  = n_eff;
                            state_next = ST_ISSUE;
                        end
                        wwt_pkg::FUNC_ADVANCE:
                        begin
                            if (CNT_W'(track_reg) >= n_eff)
                            begin
                                rem_next   = '0;
                                bit_next   = BIT_W'(IDX_W - 1);
                                state_next = ST_MODR;
                            end
                            else
                            begin
                                ptr_next   = track_reg;
                                start_next = track_reg;
                                left_next  = win;
                                state_next = ST_ISSUE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_MODR:
            begin
                // Shift in one index bit, subtract the loop size if it fits
                if (rem_shift >= {1'b0, n_eff})
                begin
                    rem_next = CNT_W'(rem_shift - {1'b0, n_eff});
                end
                else
                begin
                    rem_next = CNT_W'(rem_shift);
                end
                if (bit_reg == '0)
                begin
                    ptr_next   = IDX_W'(rem_next);
                    start_next = IDX_W'(rem_next);
                    left_next  = win;
                    state_next = ST_ISSUE;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_ISSUE:
            begin
                // Read one entry a cycle, advance the pointer around the loop
                v1_next   = 1'b1;
                left_next = left_reg - 1'b1;
                if ((CNT_W'(ptr_reg) + 1'b1) == n_eff)
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (left_reg == CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_done_next  = 1'b0;
                    out_index_next = wwt_pkg::INDEX_BITS'(track_reg);
                    out_prog_next  = wwt_pkg::INDEX_BITS'(progress_reg);
                    if (func_reg == wwt_pkg::FUNC_LOCATE)
                    begin
                        track_next     = best_idx_reg;
                        out_index_next = wwt_pkg::INDEX_BITS'(best_idx_reg);
                    end
                    else if (func_reg == wwt_pkg::FUNC_ADVANCE)
                    begin
                        track_next     = best_idx_reg;
                        out_index_next = wwt_pkg::INDEX_BITS'(best_idx_reg);
                        if (prog_sum >= {1'b0, n_eff})
                        begin
                            // Lap complete: flag and clear the count
                            progress_next = '0;
                            out_done_next = 1'b1;
                            out_prog_next = '0;
                        end
                        else
                        begin
                            progress_next = CNT_W'(prog_sum);
                            out_prog_next = wwt_pkg::INDEX_BITS'(prog_sum);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and registered result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= wwt_pkg::COUNT_BITS'(wwt_pkg::MIN_COUNT);
            track_reg     <= '0;
            progress_reg  <= '0;
            ptr_reg       <= '0;
            left_reg      <= '0;
            start_reg     <= '0;
            rem_reg       <= '0;
            bit_reg       <= '0;
            first_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_done_reg  <= 1'b0;
            out_prog_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            track_reg     <= track_next;
            progress_reg  <= progress_next;
            ptr_reg       <= ptr_next;
            left_reg      <= left_next;
            start_reg     <= start_next;
            rem_reg       <= rem_next;
            bit_reg       <= bit_next;
            first_reg     <= first_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_done_reg  <= out_done_next;
            out_prog_reg  <= out_prog_next;
        end
    end

    // Payload registers: captured item, pipeline stages, running best
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= item.func;
            px_reg   <= in_x;
            py_reg   <= in_y;
        end
        idx1_reg <= ptr_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        ax_reg   <= dx[CB] ? CB'(-dx) : CB'(dx);
        ay_reg   <= dy[CB] ? CB'(-dy) : CB'(dy);
        sqx_reg  <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sqy_reg  <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        if (take_best)
        begin
            best_d_reg   <= dist_sum;
            best_idx_reg <= idx3_reg;
        end
    end

endmodule
